FILE: rtl/core/abst_pkg.sv
// Shared types and constants for the array binary search tree core.
// Used by abst_node_store and array_bst_insert_traverse_core; no dependencies.
package abst_pkg;

   localparam int TREE_LEVELS_DEF = 6;
   localparam int KEY_BITS_DEF    = 32;

   // fixed widths of the stream fields
   localparam int CMD_W       = 3;
   localparam int KEY_PORT_W  = 32;
   localparam int SLOT_PORT_W = 6;
   localparam int KIND_W      = 2;
   localparam int RSP_USER_W  = KIND_W + 1;
   localparam int RSP_DATA_W  = ((SLOT_PORT_W + KEY_PORT_W + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT    = 3'd0,
      CMD_INORDER   = 3'd1,
      CMD_PREORDER  = 3'd2,
      CMD_POSTORDER = 3'd3,
      CMD_LEVEL     = 3'd4
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK   = 2'd0,
      KIND_KEY   = 2'd1,
      KIND_EMPTY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_DOWN,
      ST_FROM_LEFT,
      ST_FROM_RIGHT,
      ST_LEVEL,
      ST_EMPTY
   } state_type;

   // write request into the node store
   typedef struct packed {
      logic                   en;
      logic [SLOT_PORT_W-1:0] slot;
      logic [KEY_PORT_W-1:0]  key;
   } store_wr_type;

endpackage

FILE: rtl/core/abst_node_store.sv
// Node store: key memory with one registered read port, per-slot valid bits
// and an occupied-node count. Depends on abst_pkg.
module abst_node_store #(
   parameter int TREE_LEVELS = abst_pkg::TREE_LEVELS_DEF,
   parameter int KEY_W       = abst_pkg::KEY_PORT_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  abst_pkg::store_wr_type            wr,
   input  logic [TREE_LEVELS-1:0]            rd_slot,
   output logic [KEY_W-1:0]                  rd_key_ff,
   output logic [(1 << TREE_LEVELS)-2:0]     valid_ff,
   output logic [TREE_LEVELS-1:0]            count_ff
);

   localparam int SW         = TREE_LEVELS;
   localparam int SLOT_COUNT = (1 << TREE_LEVELS) - 1;

   logic [KEY_W-1:0]      key_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_in;
   logic [SW-1:0]         count_in;
   logic [SW-1:0]         wr_slot;

   assign wr_slot = wr.slot[SW-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         key_mem[wr_slot] <= wr.key[KEY_W-1:0];
      end
      rd_key_ff <= key_mem[rd_slot];
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (wr.en && !valid_ff[wr_slot]) begin
         valid_in[wr_slot] = 1'b1;
         count_in          = SW'(count_ff + SW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // inserts only ever land on empty slots
   a_write_empty: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> !valid_ff[wr_slot])
      else $error("write to an occupied slot");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(valid_ff))
      else $error("node count out of step with valid bits");

   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> count_ff == SW'($past(count_ff) + SW'(1)))
      else $error("node count missed an insert");

endmodule

FILE: rtl/core/array_bst_insert_traverse_core.sv
// Binary search tree in heap layout (children of slot i at 2i+1 and 2i+2)
// with (1 << TREE_LEVELS) - 1 slots. A beat with cmd insert walks from the
// root, one level per cycle through a single key comparator, and stores the
// key in the first empty slot (equal keys go left); it returns one
// acknowledge beat, with status 1 and slot 0 if the walk falls past the last
// level. Traversal commands return one beat per stored key in inorder,
// preorder, postorder or level (ascending slot) order, tlast on the final
// one; an empty tree returns a single kind-empty beat. The block takes one
// command at a time: req_tready is high only while idle. An insert visits at
// most TREE_LEVELS levels. Depth-first walks step through every occupied
// node up to three times (down, back from left, back from right); level
// order steps through the slots in ascending order up to the last occupied
// one. Each step reads one key through the single read port of the key
// memory. Back-pressure on rsp stalls the sequencer. The valid bits clear
// at reset; no clearing pass.
module array_bst_insert_traverse_core #(
   parameter int TREE_LEVELS = abst_pkg::TREE_LEVELS_DEF,
   parameter int KEY_BITS    = abst_pkg::KEY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [abst_pkg::KEY_PORT_W-1:0] req_tdata,  // [31:0] key
   input  logic [abst_pkg::CMD_W-1:0]      req_tuser,  // [2:0] cmd
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [abst_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [5:0] slot, [37:6] key_out, pad
   output logic [abst_pkg::RSP_USER_W-1:0] rsp_tuser,  // [1:0] kind, [2] status
   output logic                            rsp_tlast
);

   localparam int SW         = TREE_LEVELS;
   localparam int SLOT_COUNT = (1 << TREE_LEVELS) - 1;
   localparam int KW         = (KEY_BITS < abst_pkg::KEY_PORT_W) ? KEY_BITS
                                                                 : abst_pkg::KEY_PORT_W;

   // sequencer state
   abst_pkg::state_type state_ff, state_in;
   abst_pkg::cmd_type   order_ff, order_in;
   logic [SW-1:0]       slot_ff, slot_in;
   logic [KW-1:0]       key_ff, key_in;
   logic [SW-1:0]       emit_cnt_ff, emit_cnt_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   abst_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   logic                rsp_status_ff, rsp_status_in;
   logic [SW-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [KW-1:0]       rsp_key_ff, rsp_key_in;
   logic                rsp_last_ff, rsp_last_in;

   // node store
   abst_pkg::store_wr_type  wr;
   logic [KW-1:0]           rd_key;
   logic [SLOT_COUNT-1:0]   node_valid;
   logic [SW-1:0]           node_count;

   // walk helpers
   logic                out_free;
   logic [SW:0]         child_l, child_r;
   logic                child_l_occ, child_r_occ;
   logic [SW-1:0]       parent;
   logic                go_right;
   logic                emit_last;

   // move and emission chosen by the current state
   abst_pkg::state_type mv_state;
   logic [SW-1:0]       mv_slot;
   logic                emit_req;
   abst_pkg::kind_type  e_kind;
   logic                e_status;
   logic [SW-1:0]       e_slot;
   logic [KW-1:0]       e_key;
   logic                e_last;
   logic                store_req;

   abst_node_store #(
      .TREE_LEVELS (TREE_LEVELS),
      .KEY_W       (KW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .rd_slot   (slot_in),
      .rd_key_ff (rd_key),
      .valid_ff  (node_valid),
      .count_ff  (node_count)
   );

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign child_l     = {slot_ff, 1'b1};
   assign child_r     = (SW+1)'({slot_ff, 1'b0} + (SW+1)'(2));
   assign child_l_occ = (child_l < (SW+1)'(SLOT_COUNT)) && node_valid[child_l[SW-1:0]];
   assign child_r_occ = (child_r < (SW+1)'(SLOT_COUNT)) && node_valid[child_r[SW-1:0]];
   assign parent      = SW'((slot_ff - SW'(1)) >> 1);
   // stored key less than new key: go right
   assign go_right    = rd_key < key_ff;
   assign emit_last   = SW'(emit_cnt_ff + SW'(1)) == node_count;

   always_comb begin
      mv_state  = state_ff;
      mv_slot   = slot_ff;
      emit_req  = 1'b0;
      e_kind    = abst_pkg::KIND_KEY;
      e_status  = 1'b0;
      e_slot    = slot_ff;
      e_key     = rd_key;
      e_last    = emit_last;
      store_req = 1'b0;

      state_in     = state_ff;
      order_in     = order_ff;
      slot_in      = slot_ff;
      key_in       = key_ff;
      emit_cnt_in  = emit_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;

      case (state_ff)
         abst_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in      = req_tdata[KW-1:0];
               slot_in     = '0;
               emit_cnt_in = '0;
               order_in    = abst_pkg::cmd_type'(req_tuser);
               case (abst_pkg::cmd_type'(req_tuser))
                  abst_pkg::CMD_INSERT: state_in = abst_pkg::ST_INSERT;
                  abst_pkg::CMD_INORDER,
                  abst_pkg::CMD_PREORDER,
                  abst_pkg::CMD_POSTORDER: begin
                     state_in = (node_count == '0) ? abst_pkg::ST_EMPTY
                                                   : abst_pkg::ST_DOWN;
                  end
                  abst_pkg::CMD_LEVEL: begin
                     state_in = (node_count == '0) ? abst_pkg::ST_EMPTY
                                                   : abst_pkg::ST_LEVEL;
                  end
                  default: state_in = abst_pkg::ST_IDLE;  // unused codes: dropped
               endcase
            end
         end

         abst_pkg::ST_INSERT: begin
            e_kind = abst_pkg::KIND_ACK;
            e_key  = key_ff;
            e_last = 1'b1;
            if (node_valid[slot_ff]) begin
               if (go_right) begin
                  if (child_r < (SW+1)'(SLOT_COUNT)) begin
                     mv_slot = child_r[SW-1:0];
                  end else begin
                     emit_req = 1'b1;
                  end
               end else begin
                  if (child_l < (SW+1)'(SLOT_COUNT)) begin
                     mv_slot = child_l[SW-1:0];
                  end else begin
                     emit_req = 1'b1;
                  end
               end
               // fell past the last level
               e_status = 1'b1;
               e_slot   = '0;
            end else begin
               emit_req  = 1'b1;
               store_req = 1'b1;
            end
         end

         abst_pkg::ST_EMPTY: begin
            emit_req = 1'b1;
            e_kind   = abst_pkg::KIND_EMPTY;
            e_slot   = '0;
            e_key    = '0;
            e_last   = 1'b1;
         end

         abst_pkg::ST_DOWN: begin
            emit_req = (order_ff == abst_pkg::CMD_PREORDER);
            if (child_l_occ) begin
               mv_slot = child_l[SW-1:0];
            end else begin
               mv_state = abst_pkg::ST_FROM_LEFT;
            end
         end

         abst_pkg::ST_FROM_LEFT: begin
            emit_req = (order_ff == abst_pkg::CMD_INORDER);
            if (child_r_occ) begin
               mv_state = abst_pkg::ST_DOWN;
               mv_slot  = child_r[SW-1:0];
            end else begin
               mv_state = abst_pkg::ST_FROM_RIGHT;
            end
         end

         abst_pkg::ST_FROM_RIGHT: begin
            emit_req = (order_ff == abst_pkg::CMD_POSTORDER);
            if (slot_ff == '0) begin
               mv_state = abst_pkg::ST_IDLE;
            end else begin
               // odd slots are left children
               mv_state = slot_ff[0] ? abst_pkg::ST_FROM_LEFT : abst_pkg::ST_FROM_RIGHT;
               mv_slot  = parent;
            end
         end

         abst_pkg::ST_LEVEL: begin
            emit_req = node_valid[slot_ff];
            mv_slot  = SW'(slot_ff + SW'(1));
         end

         default: begin
            mv_state = abst_pkg::ST_IDLE;
         end
      endcase

      // advance unless an emission is blocked by a full output register
      if (state_ff != abst_pkg::ST_IDLE && (!emit_req || out_free)) begin
         state_in = mv_state;
         slot_in  = mv_slot;
         if (emit_req) begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = e_kind;
            rsp_status_in = e_status;
            rsp_slot_in   = e_slot;
            rsp_key_in    = e_key;
            rsp_last_in   = e_last;
            emit_cnt_in   = SW'(emit_cnt_ff + SW'(1));
            if (e_last) begin
               state_in = abst_pkg::ST_IDLE;
            end
         end
      end
   end

   always_comb begin
      wr      = '0;
      wr.en   = store_req && out_free;
      wr.slot = abst_pkg::SLOT_PORT_W'(slot_ff);
      wr.key  = abst_pkg::KEY_PORT_W'(key_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abst_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      order_ff      <= order_in;
      slot_ff       <= slot_in;
      key_ff        <= key_in;
      emit_cnt_ff   <= emit_cnt_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      rsp_tvalid = rsp_valid_ff;
      rsp_tlast  = rsp_last_ff;
      rsp_tuser  = {rsp_status_ff, rsp_kind_ff};
      rsp_tdata  = '0;
      rsp_tdata[abst_pkg::SLOT_PORT_W-1:0] = abst_pkg::SLOT_PORT_W'(rsp_slot_ff);
      rsp_tdata[abst_pkg::SLOT_PORT_W +: abst_pkg::KEY_PORT_W] =
         abst_pkg::KEY_PORT_W'(rsp_key_ff);
   end

   // depth-first walk only sits on occupied slots
   a_walk_occupied: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abst_pkg::ST_DOWN || state_ff == abst_pkg::ST_FROM_LEFT ||
       state_ff == abst_pkg::ST_FROM_RIGHT) |-> node_valid[slot_ff])
      else $error("walk on an empty slot");

   // a traversal in flight has keys left to emit
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abst_pkg::ST_DOWN || state_ff == abst_pkg::ST_FROM_LEFT ||
       state_ff == abst_pkg::ST_FROM_RIGHT || state_ff == abst_pkg::ST_LEVEL)
      |-> emit_cnt_ff < node_count)
      else $error("traversal emitted more keys than stored");

   a_insert_stores: assert property (@(posedge clock) disable iff (reset)
      (state_ff == abst_pkg::ST_INSERT && !node_valid[slot_ff] && out_free)
      |=> node_valid[$past(slot_ff)] && state_ff == abst_pkg::ST_IDLE)
      else $error("insert did not store its key");

endmodule
